// ===== src/bemp_pkg.sv =====
// Shared types and constants of the big-endian sized memory port.
`default_nettype none

package bemp_pkg;

    // Access direction
    typedef enum logic {
        OP_READ  = 1'b0,
        OP_WRITE = 1'b1
    } t_op;

    // Access size codes
    typedef enum logic [1:0] {
        SZ_BYTE = 2'd0,
        SZ_HALF = 2'd1,
        SZ_WORD = 2'd2,
        SZ_BAD  = 2'd3
    } t_size;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNALIGNED = 2'd1,
        ST_RANGE     = 2'd2,
        ST_CONSOLE   = 2'd3
    } t_status;

    localparam logic [31:0] CONSOLE_ADDR = 32'h8000_0000;
    localparam logic [7:0]  FILL_BYTE    = 8'h99;
    localparam int unsigned LANES        = 4;

    // Request from the access logic to the byte store; lane k is bits [8k+:8]
    typedef struct packed {
        logic             rd;
        logic [LANES-1:0] we;
        logic [31:0]      wdata;
    } t_mem_req;

endpackage

`default_nettype wire

// ===== src/bemp_store.sv =====
// Four-lane byte store with byte enables and a fill pass after reset.
`default_nettype none

module bemp_store #(
    parameter int unsigned WORDS = 16384,
    parameter int unsigned IDX_W = 14
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic [IDX_W-1:0]     i_idx,
    input  wire bemp_pkg::t_mem_req   i_req,
    output logic      [31:0]          o_rdata,
    output logic                      o_ready
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WORDS - 1);

    logic [bemp_pkg::LANES-1:0][7:0] r_mem [WORDS];
    logic [31:0]                     r_rdata;
    logic                            r_clearing;
    logic [IDX_W-1:0]                r_clr_idx;

    // Fill sequencer: one row per cycle from reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clearing) begin
            r_clr_idx <= r_clr_idx + 1'b1;
            if (r_clr_idx == LAST_IDX) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // Memory array: fill writes, lane writes, registered read
    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            for (int k = 0; k < bemp_pkg::LANES; k++) begin
                r_mem[r_clr_idx][k] <= bemp_pkg::FILL_BYTE;
            end
        end else begin
            for (int k = 0; k < bemp_pkg::LANES; k++) begin
                if (i_req.we[k]) begin
                    r_mem[i_idx][k] <= i_req.wdata[8*k +: 8];
                end
            end
        end
        if (i_req.rd) begin
            r_rdata <= r_mem[i_idx];
        end
    end

    assign o_rdata = r_rdata;
    assign o_ready = !r_clearing;

endmodule

`default_nettype wire

// ===== src/big_endian_sized_memory_port.sv =====
// Top level of the big-endian sized memory port.
`default_nettype none

// Byte-addressed memory slave serving 8, 16 and 32-bit reads and writes,
// stored big-endian (lowest address is the most significant byte). Bytes
// live in four byte lanes of one synchronous memory of ceil(MEM_BYTES/4)
// rows. After reset a fill pass writes 0x99 to every row, one row per
// cycle; the input is not ready until the fill pass ends. Then one word
// is taken per cycle unless the output stalls; a result passes the pending
// stage (where the memory's registered read arrives) and the output register.
// Misaligned halfword/word accesses answer unaligned, a write to 0x80000000
// answers console with its low byte, and accesses reaching past MEM_BYTES
// (or size code three) answer out of range; none of these touch memory.
module big_endian_sized_memory_port #(
    parameter longint unsigned MEM_BYTES = 65536
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // [0] operation, [2:1] access_size, [34:3] address, [66:35] write_data,
    // [71:67] zero
    input  wire logic [71:0] i_s_axis_tdata,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // [31:0] read_data, [33:32] status, [34] console_valid,
    // [42:35] console_char, [47:43] zero
    output logic      [47:0] o_m_axis_tdata
);

    localparam int unsigned WORDS     = int'((MEM_BYTES + 3) / 4);
    localparam int unsigned IDX_W     = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam logic [32:0] MEM_LIMIT = 33'(MEM_BYTES);

    // Input word fields
    logic                 in_op;
    bemp_pkg::t_size      in_size;
    logic [31:0]          in_addr;
    logic [31:0]          in_wdata;
    logic [32:0]          in_end;
    logic                 in_accept;
    bemp_pkg::t_status    in_status;
    bemp_pkg::t_mem_req   mem_req;
    logic [IDX_W-1:0]     mem_idx;
    logic [31:0]          mem_rdata;
    logic                 mem_ready;

    // Pending stage (memory data arrives) and output register
    logic                 r_p_valid;
    logic                 r_p_rd;
    bemp_pkg::t_size      r_p_size;
    logic [1:0]           r_p_lo;
    bemp_pkg::t_status    r_p_status;
    logic [7:0]           r_p_char;
    logic                 r_o_valid;
    logic [47:0]          r_o_data;
    logic                 move;
    logic [31:0]          p_rdata;
    logic [31:0]          q_be;

    assign in_op    = i_s_axis_tdata[0];
    assign in_size  = bemp_pkg::t_size'(i_s_axis_tdata[2:1]);
    assign in_addr  = i_s_axis_tdata[34:3];
    assign in_wdata = i_s_axis_tdata[66:35];
    assign in_end   = {1'b0, in_addr} + ((in_size == bemp_pkg::SZ_WORD) ? 33'd4 :
                      (in_size == bemp_pkg::SZ_HALF) ? 33'd2 : 33'd1);

    // Classification: size, alignment, console, range, in that order
    always_comb begin
        priority if (in_size == bemp_pkg::SZ_BAD) begin
            in_status = bemp_pkg::ST_RANGE;
        end else if ((in_size == bemp_pkg::SZ_HALF && in_addr[0]) ||
                     (in_size == bemp_pkg::SZ_WORD && in_addr[1:0] != 2'b00)) begin
            in_status = bemp_pkg::ST_UNALIGNED;
        end else if (in_op == bemp_pkg::OP_WRITE && in_addr == bemp_pkg::CONSOLE_ADDR) begin
            in_status = bemp_pkg::ST_CONSOLE;
        end else if (in_end > MEM_LIMIT) begin
            in_status = bemp_pkg::ST_RANGE;
        end else begin
            in_status = bemp_pkg::ST_OK;
        end
    end

    // Handshake: pending stage drains into the output register when it is free
    assign move            = !r_o_valid || i_m_axis_tready;
    assign o_s_axis_tready = mem_ready && (!r_p_valid || move);
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;

    // Memory request: lane enables and lane data in big-endian order
    always_comb begin
        mem_idx       = in_addr[IDX_W+1:2];
        mem_req.rd    = in_accept && in_status == bemp_pkg::ST_OK &&
                        in_op == bemp_pkg::OP_READ;
        mem_req.we    = '0;
        mem_req.wdata = {4{in_wdata[7:0]}};
        unique case (in_size)
            bemp_pkg::SZ_WORD: begin
                mem_req.wdata = {in_wdata[7:0], in_wdata[15:8],
                                 in_wdata[23:16], in_wdata[31:24]};
                mem_req.we    = 4'b1111;
            end
            bemp_pkg::SZ_HALF: begin
                mem_req.wdata = {in_wdata[7:0], in_wdata[15:8],
                                 in_wdata[7:0], in_wdata[15:8]};
                mem_req.we    = in_addr[1] ? 4'b1100 : 4'b0011;
            end
            bemp_pkg::SZ_BYTE: begin
                mem_req.we = 4'b0001 << in_addr[1:0];
            end
            default: begin
                mem_req.we = '0;
            end
        endcase
        if (!(in_accept && in_status == bemp_pkg::ST_OK && in_op == bemp_pkg::OP_WRITE)) begin
            mem_req.we = '0;
        end
    end

    bemp_store #(
        .WORDS (WORDS),
        .IDX_W (IDX_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_idx   (mem_idx),
        .i_req   (mem_req),
        .o_rdata (mem_rdata),
        .o_ready (mem_ready)
    );

    // Pending stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (in_accept) begin
            r_p_valid <= 1'b1;
        end else if (move) begin
            r_p_valid <= 1'b0;
        end
    end

    // Pending stage payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_p_rd     <= mem_req.rd;
            r_p_size   <= in_size;
            r_p_lo     <= in_addr[1:0];
            r_p_status <= in_status;
            r_p_char   <= in_wdata[7:0];
        end
    end

    // Read assembly: lane 0 holds the most significant byte
    assign q_be = {mem_rdata[7:0], mem_rdata[15:8], mem_rdata[23:16], mem_rdata[31:24]};

    always_comb begin
        p_rdata = '0;
        if (r_p_rd) begin
            unique case (r_p_size)
                bemp_pkg::SZ_WORD: p_rdata = q_be;
                bemp_pkg::SZ_HALF: p_rdata = r_p_lo[1] ? {16'd0, q_be[15:0]}
                                                       : {16'd0, q_be[31:16]};
                bemp_pkg::SZ_BYTE: p_rdata = {24'd0, mem_rdata[8*r_p_lo +: 8]};
                default:           p_rdata = '0;
            endcase
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (move) begin
            r_o_valid <= r_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move && r_p_valid) begin
            r_o_data <= {5'd0,
                         (r_p_status == bemp_pkg::ST_CONSOLE) ? r_p_char : 8'd0,
                         r_p_status == bemp_pkg::ST_CONSOLE,
                         r_p_status,
                         p_rdata};
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = r_o_data;

endmodule

`default_nettype wire

// ===== bench/tb_mem_sb_pkg.sv =====
// Scoreboard for the big-endian sized memory port: byte image, predictor and result checks.
`timescale 1ns / 100ps

package tb_mem_sb_pkg;

    import bemp_pkg::*;

    localparam int unsigned MEM_SIZE = 65536;

    // One access as the block sees it
    typedef struct {
        t_op         op;
        t_size       sz;
        logic [31:0] addr;
        logic [31:0] wdata;
    } t_access;

    // One answer of the block
    typedef struct {
        logic [31:0] rd;
        t_status     st;
        logic        cv;
        logic [7:0]  ch;
    } t_answer;

    class mem_scoreboard;

        bit [7:0] mem_image [MEM_SIZE];
        t_answer  answers_due [$];
        int       fail_count;

        function new();
            foreach (mem_image[i]) mem_image[i] = FILL_BYTE;
            fail_count = 0;
        endfunction

        // One line per mismatch; the count decides the verdict
        function void report(string msg);
            fail_count++;
            $display("MISMATCH @%0t: %s", $time, msg);
        endfunction

        function int pending();
            return answers_due.size();
        endfunction

        // Work out the answer to an accepted access and update the byte image
        function void note_access(t_access a);
            t_answer      ans;
            logic [31:0]  nbytes;
            logic [32:0]  last_end;
            logic [31:0]  acc;
            int unsigned  k;

            ans = '{rd: '0, st: ST_OK, cv: 1'b0, ch: '0};
            nbytes = 32'd1 << a.sz;
            last_end = {1'b0, a.addr} + {1'b0, nbytes};
            if (a.sz == SZ_BAD) begin
                ans.st = ST_RANGE;
            end else if ((a.addr & (nbytes - 32'd1)) != 32'd0) begin
                ans.st = ST_UNALIGNED;
            end else if (a.op == OP_WRITE && a.addr == CONSOLE_ADDR) begin
                ans.st = ST_CONSOLE;
                ans.cv = 1'b1;
                ans.ch = a.wdata[7:0];
            end else if (last_end > 33'(MEM_SIZE)) begin
                ans.st = ST_RANGE;
            end else if (a.op == OP_WRITE) begin
                // lowest address takes the most significant byte
                for (k = 0; k < nbytes; k++)
                    mem_image[a.addr + k] = a.wdata[8 * (nbytes - 1 - k) +: 8];
            end else begin
                acc = '0;
                for (k = 0; k < nbytes; k++)
                    acc = {acc[23:0], mem_image[a.addr + k]};
                ans.rd = acc;
            end
            answers_due.push_back(ans);
        endfunction

        // Compare an accepted output word with the oldest answer due
        function void check_result(logic [47:0] d);
            t_answer ans;
            if (answers_due.size() == 0) begin
                report($sformatf("result with nothing due: %h", d));
                return;
            end
            ans = answers_due.pop_front();
            if (d[31:0] !== ans.rd)
                report($sformatf("read_data %h, want %h", d[31:0], ans.rd));
            if (d[33:32] !== ans.st)
                report($sformatf("status %0d, want %0d", d[33:32], ans.st));
            if (d[34] !== ans.cv)
                report($sformatf("console_valid %b, want %b", d[34], ans.cv));
            if (d[42:35] !== ans.ch)
                report($sformatf("console_char %h, want %h", d[42:35], ans.ch));
        endfunction

    endclass

endpackage

// ===== bench/tb_top.sv =====
// Top of the testbench for the big-endian sized memory port.
`timescale 1ns / 100ps

module tb_top;

    import bemp_pkg::*;
    import tb_mem_sb_pkg::*;

    localparam int RANDOM_ITEMS = 1150;
    localparam int IDLE_LIMIT   = 100000;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AT      = 300;
    localparam int DRAIN_CYCLES = 8;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [71:0] s_data = '0;
    logic        m_ready = 1'b0;
    wire         s_ready;
    wire         m_valid;
    wire  [47:0] m_data;

    mem_scoreboard sb = new();
    int            idle_cycles = 0;
    int            results_seen = 0;

    always #5 i_clk = ~i_clk;

    big_endian_sized_memory_port #(
        .MEM_BYTES(MEM_SIZE)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(s_valid),
        .o_s_axis_tready(s_ready),
        // [0] operation, [2:1] access_size, [34:3] address, [66:35] write_data
        .i_s_axis_tdata (s_data),
        .o_m_axis_tvalid(m_valid),
        .i_m_axis_tready(m_ready),
        // [31:0] read_data, [33:32] status, [34] console_valid, [42:35] console_char
        .o_m_axis_tdata (m_data)
    );

    // Offer one word and hold it until taken
    task automatic send_access(input t_op op, input t_size sz,
                               input logic [31:0] addr, input logic [31:0] wdata);
        t_access a;
        a = '{op: op, sz: sz, addr: addr, wdata: wdata};
        s_valid <= 1'b1;
        s_data  <= {5'b0, wdata, addr, sz, op};
        do @(posedge i_clk); while (!s_ready);
        sb.note_access(a);
    endtask

    // Random access, mostly well-formed and in a small window so reads hit written bytes
    task automatic send_random();
        int unsigned kind;
        t_op         op;
        t_size       sz;
        logic [31:0] addr;
        logic [31:0] nbytes;
        kind = $urandom_range(0, 99);
        op   = t_op'($urandom_range(0, 1));
        sz   = ($urandom_range(0, 99) < 3) ? SZ_BAD : t_size'($urandom_range(0, 2));
        if (kind < 65) begin
            addr = $urandom_range(0, 255);
        end else if (kind < 77) begin
            addr = MEM_SIZE - 16 + $urandom_range(0, 31);
        end else if (kind < 85) begin
            addr = CONSOLE_ADDR + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
            if ($urandom_range(0, 3) != 0) op = OP_WRITE;
        end else begin
            addr = $urandom();
        end
        nbytes = 32'd1 << sz;
        if (kind < 85 && sz != SZ_BAD && $urandom_range(0, 9) < 8)
            addr = addr & ~(nbytes - 32'd1);
        send_access(op, sz, addr, $urandom());
    endtask

    // Reset, directed accesses, then bursts of random ones
    initial begin
        int burst_left;
        int i;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // initial fill pattern in all three sizes
        send_access(OP_READ,  SZ_BYTE, 32'h0000_0000, 32'h0);
        send_access(OP_READ,  SZ_HALF, 32'h0000_0000, 32'h0);
        send_access(OP_READ,  SZ_WORD, 32'h0000_0000, 32'h0);
        // byte order of stores and narrow reads
        send_access(OP_WRITE, SZ_WORD, 32'h0000_0000, 32'hA1B2_C3D4);
        send_access(OP_READ,  SZ_WORD, 32'h0000_0000, 32'h0);
        send_access(OP_READ,  SZ_BYTE, 32'h0000_0001, 32'h0);
        send_access(OP_READ,  SZ_HALF, 32'h0000_0002, 32'h0);
        send_access(OP_WRITE, SZ_BYTE, 32'h0000_0003, 32'hFFFF_FFFF);
        send_access(OP_WRITE, SZ_HALF, 32'h0000_0006, 32'h0000_BEEF);
        send_access(OP_READ,  SZ_WORD, 32'h0000_0004, 32'h0);
        send_access(OP_READ,  SZ_WORD, 32'h0000_0000, 32'h0);
        // top end of the memory
        send_access(OP_WRITE, SZ_WORD, MEM_SIZE - 4, 32'hFFFF_FFFF);
        send_access(OP_READ,  SZ_WORD, MEM_SIZE - 4, 32'h0);
        send_access(OP_READ,  SZ_BYTE, MEM_SIZE - 1, 32'h0);
        send_access(OP_READ,  SZ_HALF, MEM_SIZE - 2, 32'h0);
        // misaligned and out of range
        send_access(OP_READ,  SZ_WORD, MEM_SIZE - 2, 32'h0);
        send_access(OP_WRITE, SZ_HALF, MEM_SIZE - 1, 32'h1234_5678);
        send_access(OP_READ,  SZ_WORD, MEM_SIZE, 32'h0);
        send_access(OP_READ,  SZ_BYTE, 32'hFFFF_FFFF, 32'h0);
        send_access(OP_WRITE, SZ_WORD, 32'hFFFF_FFFC, 32'h0);
        // console writes, console read, misaligned console write
        send_access(OP_WRITE, SZ_BYTE, CONSOLE_ADDR, 32'h1234_5678);
        send_access(OP_WRITE, SZ_HALF, CONSOLE_ADDR, 32'hFFFF_FFFF);
        send_access(OP_WRITE, SZ_WORD, CONSOLE_ADDR, 32'h0);
        send_access(OP_READ,  SZ_WORD, CONSOLE_ADDR, 32'h0);
        send_access(OP_WRITE, SZ_WORD, CONSOLE_ADDR + 2, 32'h55);
        // size code three
        send_access(OP_READ,  SZ_BAD,  32'h0000_0000, 32'h0);
        send_access(OP_WRITE, SZ_BAD,  CONSOLE_ADDR, 32'hAA);

        // random part in bursts with gaps
        burst_left = $urandom_range(1, 24);
        for (i = 0; i < RANDOM_ITEMS; i++) begin
            send_random();
            burst_left--;
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                if ($urandom_range(0, 3) != 0) begin
                    s_valid <= 1'b0;
                    repeat ($urandom_range(1, 6)) @(posedge i_clk);
                end
            end
        end
        s_valid <= 1'b0;

        // drain and settle
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Receiver: check each word taken, then pick the next ready level
    initial begin
        int hold_left;
        bit held;
        int cyc;
        int mode;
        hold_left = 0;
        held = 1'b0;
        cyc = 0;
        mode = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (m_ready && m_valid) begin
                sb.check_result(m_data);
                results_seen++;
            end
            cyc++;
            if (cyc % 64 == 0) mode = $urandom_range(0, 2);
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!held && results_seen >= HOLD_AT) begin
                // long hold-off so the block fills and stalls its input
                held = 1'b1;
                hold_left = HOLD_CYCLES;
                m_ready <= 1'b0;
            end else begin
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= ($urandom_range(0, 3) != 0);
                    default: m_ready <= (cyc % 5 != 0) && (cyc % 7 != 3);
                endcase
            end
        end
    end

    // Watchdog on cycles with no word moving on either side
    always @(posedge i_clk) begin
        if ((s_valid && s_ready) || (m_ready && m_valid)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

endmodule
